FILE: rtl/core/som_pkg.sv
// Shared types, codes and the 2^(-k/16) table for the SOM training block.
package som_pkg;

  localparam int unsigned DistW = 48;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
  localparam logic [31:0] Log2eQ16 = 32'd94548;

  localparam logic [1:0] FuncWrite  = 2'd0;
  localparam logic [1:0] FuncSample = 2'd1;
  localparam logic [1:0] FuncRead   = 2'd2;

  localparam logic KindWinner = 1'b0;
  localparam logic KindWeight = 1'b1;

  localparam logic [7:0] RegLearningRate = 8'd0;
  localparam logic [7:0] RegInvRadius    = 8'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  neuron_row;
    logic [2:0]  neuron_col;
    logic [9:0]  element_index;
    logic [31:0] weight_in;
    logic [15:0] sample_value;
    logic        last_element;
  } som_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  winner_row;
    logic [2:0]  winner_col;
    logic [47:0] min_distance;
    logic [31:0] weight_out;
  } som_out_t;

  // round(65536 * 2^(-k/16)), k = 0..16
  function automatic logic [16:0] pow2_neg(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/som_ram.sv
// Single-port RAM with registered read data.
module som_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

FILE: rtl/core/som_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
module som_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= 64'(a_i) * 64'(b_i);
  end

endmodule

FILE: rtl/core/som_winner_and_weight_update_top.sv
// Top level: SOM distance accumulation, winner search and weight update sequencer.
//
//  channel | signals                              | dir | notes
//  item    | start, busy, in_i                    | in  | taken when start & !busy
//  result  | res_valid_o, res_o                   | out | one-cycle strobe
//  config  | cfg_valid_i, cfg_ready_o, cfg_*_i    | in  | always ready
//
// Weight write: decode only. Weight read: decode and read out. Sample element: DRD, DSUB,
// DACC per neuron, serialized by one weight memory port and the shared multiplier.
// Closing element adds a MIN winner search, then the update: G..COEF per neuron, URD..UWR per element.
// Reset clears the FSM, position and distance sums; memories are undefined until written.
// The result receiver cannot stall; busy stays high until the item is done.
module som_winner_and_weight_update_top #(
  parameter int unsigned MAP_ROWS    = 5,
  parameter int unsigned MAP_COLS    = 5,
  parameter int unsigned VECTOR_LEN  = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  som_pkg::som_in_t  in_i,
  output logic              res_valid_o,
  output som_pkg::som_out_t res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  localparam int unsigned Neurons = MAP_ROWS * MAP_COLS;
  localparam int unsigned Words   = Neurons * VECTOR_LEN;
  localparam int unsigned AW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned EW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int unsigned KW = (Neurons > 1) ? $clog2(Neurons) : 1;
  localparam int unsigned RW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int unsigned CW = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
  localparam int unsigned SB = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
  localparam int unsigned DW = som_pkg::DistW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RDOUT = 4'd2;
  localparam logic [3:0] S_DRD   = 4'd3;
  localparam logic [3:0] S_DSUB  = 4'd4;
  localparam logic [3:0] S_DACC  = 4'd5;
  localparam logic [3:0] S_MIN   = 4'd6;
  localparam logic [3:0] S_G     = 4'd7;
  localparam logic [3:0] S_Y     = 4'd8;
  localparam logic [3:0] S_M     = 4'd9;
  localparam logic [3:0] S_NF    = 4'd10;
  localparam logic [3:0] S_COEF  = 4'd11;
  localparam logic [3:0] S_URD   = 4'd12;
  localparam logic [3:0] S_UMUL  = 4'd13;
  localparam logic [3:0] S_UWR   = 4'd14;

  logic [3:0] state_q, state_d;
  som_pkg::som_in_t item_q, item_d;
  logic [EW-1:0] pos_q, pos_d, e_q, e_d;
  logic [KW-1:0] k_q, k_d;
  logic [RW-1:0] r_q, r_d, wr_q, wr_d;
  logic [CW-1:0] c_q, c_d, wc_q, wc_d;
  logic [AW-1:0] base_q, base_d;
  logic          close_q, close_d;
  logic [DW-1:0] best_q, best_d;
  logic [DW-1:0] dist_q [Neurons];
  logic          dist_we;
  logic [DW-1:0] dist_wdata;
  logic [4:0]    n_q, n_d;
  logic [16:0]   ti_q, ti_d;
  logic [15:0]   coef_q, coef_d;
  logic [31:0]   w_q, w_d;
  logic          up_q, up_d;
  logic [15:0]   lr_q, irad_q;
  logic          res_valid_q, res_valid_d;
  som_pkg::som_out_t res_q, res_d;

  // memory and multiplier hookups
  logic          wm_we, sm_we;
  logic [AW-1:0] wm_addr;
  logic [31:0]   wm_wdata, wm_rdata;
  logic [EW-1:0] sm_addr;
  logic [SB-1:0] sm_rdata;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;

  som_ram #(.Depth(Words), .Width(32), .AddrW(AW)) u_wmem (
    .clk_i, .we_i(wm_we), .addr_i(wm_addr), .wdata_i(wm_wdata), .rdata_o(wm_rdata)
  );

  som_ram #(.Depth(VECTOR_LEN), .Width(SB), .AddrW(EW)) u_smem (
    .clk_i, .we_i(sm_we), .addr_i(sm_addr), .wdata_i(item_q.sample_value[SB-1:0]),
    .rdata_o(sm_rdata)
  );

  som_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  // item decode
  logic          addr_ok;
  logic [AW-1:0] item_addr;
  logic [31:0]   samp_t;
  assign addr_ok = (32'(item_q.neuron_row) < MAP_ROWS) && (32'(item_q.neuron_col) < MAP_COLS)
                 && (32'(item_q.element_index) < VECTOR_LEN);
  assign item_addr = AW'((32'(item_q.neuron_row) * MAP_COLS + 32'(item_q.neuron_col))
                         * VECTOR_LEN + 32'(item_q.element_index));
  assign samp_t = {16'(item_q.sample_value[SB-1:0]), 16'h0};

  // datapath pieces
  logic [31:0]   dabs, tgt, udiff;
  logic [DW:0]   dsum;
  logic [RW-1:0] dr;
  logic [CW-1:0] dc;
  logic [9:0]    g;
  logic [31:0]   y;
  logic [16:0]   m, msh;
  logic [15:0]   nf;
  logic [DW-1:0] dcur;
  logic          take;

  assign dabs  = (wm_rdata > samp_t) ? wm_rdata - samp_t : samp_t - wm_rdata;
  assign dsum  = (DW+1)'(dist_q[k_q]) + (DW+1)'(prod[63:32]);
  assign tgt   = {16'(sm_rdata), 16'h0};
  assign udiff = (tgt >= wm_rdata) ? tgt - wm_rdata : wm_rdata - tgt;
  assign dr    = (r_q > wr_q) ? r_q - wr_q : wr_q - r_q;
  assign dc    = (c_q > wc_q) ? c_q - wc_q : wc_q - c_q;
  assign g     = 10'(dr) * 10'(dr) + 10'(dc) * 10'(dc);
  assign y     = prod[41:10];
  assign m     = ti_q - 17'(prod[28:12]);
  assign msh   = m >> n_q;
  assign nf    = (n_q > 5'd16) ? 16'h0 : ((msh > 17'd65535) ? 16'hFFFF : msh[15:0]);
  assign dcur  = dist_q[k_q];
  assign take  = (k_q == '0) || (dcur < best_q);

  always_comb begin
    mul_a = 32'(item_q.weight_in);
    mul_b = 32'(item_q.weight_in);
    unique case (state_q)
      S_DSUB: begin mul_a = dabs; mul_b = dabs; end
      S_G:    begin mul_a = 32'(g); mul_b = 32'(irad_q); end
      S_Y:    begin mul_a = prod[31:0]; mul_b = som_pkg::Log2eQ16; end
      S_M:    begin
        mul_a = 32'(som_pkg::pow2_neg({1'b0, y[15:12]})
                    - som_pkg::pow2_neg(5'({1'b0, y[15:12]}) + 5'd1));
        mul_b = 32'(y[11:0]);
      end
      S_NF:   begin mul_a = 32'(lr_q); mul_b = 32'(nf); end
      S_UMUL: begin mul_a = udiff; mul_b = 32'(coef_q); end
      default: begin mul_a = 32'(item_q.weight_in); mul_b = 32'(item_q.weight_in); end
    endcase
  end

  always_comb begin
    state_d = state_q;
    item_d = item_q;
    pos_d = pos_q; e_d = e_q; k_d = k_q;
    r_d = r_q; c_d = c_q; wr_d = wr_q; wc_d = wc_q;
    base_d = base_q; close_d = close_q; best_d = best_q;
    n_d = n_q; ti_d = ti_q; coef_d = coef_q; w_d = w_q; up_d = up_q;
    res_valid_d = 1'b0;
    res_d = res_q;
    wm_we = 1'b0; wm_addr = base_q; wm_wdata = item_q.weight_in;
    sm_we = 1'b0; sm_addr = e_q;
    dist_we = 1'b0; dist_wdata = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d = in_i;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_IDLE;
        wm_addr = item_addr;
        priority if (item_q.func == som_pkg::FuncWrite) begin
          wm_we = addr_ok;
        end else if (item_q.func == som_pkg::FuncRead) begin
          if (addr_ok) begin
            state_d = S_RDOUT;
          end else begin
            res_valid_d = 1'b1;
            res_d = '0;
            res_d.result_kind = som_pkg::KindWeight;
          end
        end else if (item_q.func == som_pkg::FuncSample) begin
          sm_we = 1'b1;
          sm_addr = pos_q;
          close_d = item_q.last_element || (32'(pos_q) == VECTOR_LEN - 1);
          k_d = '0;
          base_d = AW'(pos_q);
          state_d = S_DRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RDOUT: begin
        res_valid_d = 1'b1;
        res_d = '0;
        res_d.result_kind = som_pkg::KindWeight;
        res_d.weight_out = wm_rdata;
        state_d = S_IDLE;
      end
      S_DRD: state_d = S_DSUB;
      S_DSUB: state_d = S_DACC;
      S_DACC: begin
        dist_we = 1'b1;
        dist_wdata = (dsum > (DW+1)'(som_pkg::DistMax)) ? som_pkg::DistMax : dsum[DW-1:0];
        if (32'(k_q) == Neurons - 1) begin
          k_d = '0;
          r_d = '0;
          c_d = '0;
          if (close_q) begin
            state_d = S_MIN;
          end else begin
            pos_d = pos_q + EW'(1);
            state_d = S_IDLE;
          end
        end else begin
          k_d = k_q + KW'(1);
          base_d = base_q + AW'(VECTOR_LEN);
          state_d = S_DRD;
        end
      end
      S_MIN: begin
        if (take) begin
          best_d = dcur;
          wr_d = r_q;
          wc_d = c_q;
        end
        if (32'(c_q) == MAP_COLS - 1) begin
          c_d = '0;
          r_d = r_q + RW'(1);
        end else begin
          c_d = c_q + CW'(1);
        end
        k_d = k_q + KW'(1);
        if (32'(k_q) == Neurons - 1) begin
          res_valid_d = 1'b1;
          res_d = '0;
          res_d.result_kind = som_pkg::KindWinner;
          res_d.winner_row = take ? 3'(r_q) : 3'(wr_q);
          res_d.winner_col = take ? 3'(c_q) : 3'(wc_q);
          res_d.min_distance = take ? dcur : best_q;
          k_d = '0;
          r_d = '0;
          c_d = '0;
          base_d = '0;
          state_d = S_G;
        end
      end
      S_G: state_d = S_Y;
      S_Y: state_d = S_M;
      S_M: begin
        n_d = (prod[63:26] > 38'd16) ? 5'd17 : prod[30:26];
        ti_d = som_pkg::pow2_neg({1'b0, y[15:12]});
        state_d = S_NF;
      end
      S_NF: state_d = S_COEF;
      S_COEF: begin
        coef_d = prod[31:16];
        dist_we = 1'b1;
        e_d = '0;
        state_d = S_URD;
      end
      S_URD: begin
        wm_addr = base_q + AW'(e_q);
        state_d = S_UMUL;
      end
      S_UMUL: begin
        w_d = wm_rdata;
        up_d = (tgt >= wm_rdata);
        state_d = S_UWR;
      end
      S_UWR: begin
        wm_we = 1'b1;
        wm_addr = base_q + AW'(e_q);
        wm_wdata = up_q ? w_q + prod[47:16] : w_q - prod[47:16];
        if (e_q == pos_q) begin
          if (32'(k_q) == Neurons - 1) begin
            pos_d = '0;
            state_d = S_IDLE;
          end else begin
            k_d = k_q + KW'(1);
            base_d = base_q + AW'(VECTOR_LEN);
            if (32'(c_q) == MAP_COLS - 1) begin
              c_d = '0;
              r_d = r_q + RW'(1);
            end else begin
              c_d = c_q + CW'(1);
            end
            state_d = S_G;
          end
        end else begin
          e_d = e_q + EW'(1);
          state_d = S_URD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q <= '0;
      res_valid_q <= 1'b0;
      lr_q <= 16'd1311;
      irad_q <= 16'd341;
      for (int i = 0; i < Neurons; i++) dist_q[i] <= '0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      res_valid_q <= res_valid_d;
      if (dist_we) dist_q[k_q] <= dist_wdata;
      if (cfg_valid_i && cfg_index_i == som_pkg::RegLearningRate) lr_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == som_pkg::RegInvRadius) irad_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    e_q <= e_d; k_q <= k_d;
    r_q <= r_d; c_q <= c_d; wr_q <= wr_d; wc_q <= wc_d;
    base_q <= base_d; close_q <= close_d; best_q <= best_d;
    n_q <= n_d; ti_q <= ti_d; coef_q <= coef_d; w_q <= w_d; up_q <= up_d;
    res_q <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result strobes back to back");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < VECTOR_LEN) else $error("element counter past vector");
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item left block idle");

endmodule

FILE: bench/som_training_checker.sv
// Checker for the SOM training block: watches item, result and register transfers.
module som_training_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  som_pkg::som_in_t  item_i,
  input  logic              res_valid_i,
  input  som_pkg::som_out_t res_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [7:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output int                fail_count_o,
  output int                items_taken_o,
  output int                cfg_taken_o,
  output int                pending_o
);

  localparam int Rows = 5;
  localparam int Cols = 5;
  localparam int Neurons = Rows * Cols;
  localparam int VecLen = 1024;

  localparam int unsigned Pow2Tab [17] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
    46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  logic [15:0] rate_q;
  logic [15:0] inv_radius_q;
  logic [31:0] weights [Neurons*VecLen];
  logic [15:0] sample_buf [VecLen];
  logic [47:0] dist_sums [Neurons];
  int unsigned elem_pos;

  som_pkg::som_out_t winner_reports [$];

  assign pending_o = winner_reports.size();

  // exp(-x/1024) in Q0.16, x in Q.10
  function automatic int unsigned decay_q16(longint unsigned x);
    longint unsigned y, n;
    int unsigned f, i, t, m, r;
    y = (x * 64'd94548) >> 10;
    n = y >> 16;
    f = int'(y & 64'hFFFF);
    i = f >> 12;
    t = f & 4095;
    m = Pow2Tab[i] - (((Pow2Tab[i] - Pow2Tab[i+1]) * t) >> 12);
    if (n > 16) return 0;
    r = m >> n;
    return (r > 65535) ? 65535 : r;
  endfunction

  task automatic close_vector(int unsigned count);
    int best;
    int wr, wc, dr, dc;
    longint unsigned g, coef, target, w;
    som_pkg::som_out_t rep;
    best = 0;
    for (int k = 1; k < Neurons; k++)
      if (dist_sums[k] < dist_sums[best]) best = k;
    wr = best / Cols;
    wc = best % Cols;
    rep = '0;
    rep.result_kind = som_pkg::KindWinner;
    rep.winner_row = 3'(wr);
    rep.winner_col = 3'(wc);
    rep.min_distance = dist_sums[best];
    winner_reports.push_back(rep);
    for (int k = 0; k < Neurons; k++) begin
      dr = (k / Cols) - wr;
      dc = (k % Cols) - wc;
      g = longint'(dr * dr + dc * dc);
      coef = (longint'(rate_q) * decay_q16(g * inv_radius_q)) >> 16;
      for (int e = 0; e < count; e++) begin
        target = longint'(sample_buf[e]) << 16;
        w = weights[k*VecLen + e];
        if (target >= w) w = w + (((target - w) * coef) >> 16);
        else w = w - (((w - target) * coef) >> 16);
        weights[k*VecLen + e] = w[31:0];
      end
      dist_sums[k] = '0;
    end
    elem_pos = 0;
  endtask

  task automatic take_item(som_pkg::som_in_t it);
    logic in_grid;
    int unsigned addr, pos;
    longint unsigned w, s, d, sum;
    som_pkg::som_out_t rd;
    in_grid = (it.neuron_row < Rows) && (it.neuron_col < Cols);
    addr = (it.neuron_row * Cols + it.neuron_col) * VecLen + it.element_index;
    case (it.func)
      som_pkg::FuncWrite: if (in_grid) weights[addr] = it.weight_in;
      som_pkg::FuncRead: begin
        rd = '0;
        rd.result_kind = som_pkg::KindWeight;
        rd.weight_out = in_grid ? weights[addr] : '0;
        winner_reports.push_back(rd);
      end
      som_pkg::FuncSample: begin
        pos = (elem_pos >= VecLen) ? VecLen - 1 : elem_pos;
        sample_buf[pos] = it.sample_value;
        s = longint'(it.sample_value) << 16;
        for (int k = 0; k < Neurons; k++) begin
          w = weights[k*VecLen + pos];
          d = (w > s) ? w - s : s - w;
          sum = dist_sums[k] + ((d * d) >> 32);
          dist_sums[k] = (sum > 64'(som_pkg::DistMax)) ? som_pkg::DistMax : sum[47:0];
        end
        if (it.last_element || pos == VecLen - 1) close_vector(pos + 1);
        else elem_pos = pos + 1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    som_pkg::som_out_t exp_res;
    if (!rst_ni) begin
      rate_q <= 16'd1311;
      inv_radius_q <= 16'd341;
      for (int k = 0; k < Neurons; k++) dist_sums[k] = '0;
      elem_pos = 0;
    end else begin
      if (res_valid_i) begin
        if (winner_reports.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count_o++;
        end else begin
          exp_res = winner_reports.pop_front();
          if (res_i.result_kind !== exp_res.result_kind) begin
            $error("result_kind exp %0d got %0d", exp_res.result_kind, res_i.result_kind);
            fail_count_o++;
          end
          if (res_i.winner_row !== exp_res.winner_row) begin
            $error("winner_row exp %0d got %0d", exp_res.winner_row, res_i.winner_row);
            fail_count_o++;
          end
          if (res_i.winner_col !== exp_res.winner_col) begin
            $error("winner_col exp %0d got %0d", exp_res.winner_col, res_i.winner_col);
            fail_count_o++;
          end
          if (res_i.min_distance !== exp_res.min_distance) begin
            $error("min_distance exp %0d got %0d", exp_res.min_distance, res_i.min_distance);
            fail_count_o++;
          end
          if (res_i.weight_out !== exp_res.weight_out) begin
            $error("weight_out exp %0h got %0h", exp_res.weight_out, res_i.weight_out);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        take_item(item_i);
        items_taken_o++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == som_pkg::RegLearningRate) rate_q <= cfg_data_i;
        else if (cfg_index_i == som_pkg::RegInvRadius) inv_radius_q <= cfg_data_i;
        cfg_taken_o++;
      end
    end
  end

endmodule

FILE: bench/tb_som_winner_and_weight_update_top.sv
// Testbench top for the SOM training block: stimulus, register phases and verdict.
module tb_som_winner_and_weight_update_top;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int CycleLimit = 10000000;
  // elements preloaded in every neuron; vectors and in-grid random reads stay below this
  localparam int PreloadLen = 16;
  localparam int MaxLooseOpen = 3;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  som_pkg::som_in_t  item;
  logic        res_valid;
  som_pkg::som_out_t res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count, items_taken, cfg_taken, pending;
  int cycles;
  int open_elems;

  som_winner_and_weight_update_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .in_i        (item),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  som_training_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (item),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .items_taken_o(items_taken),
    .cfg_taken_o  (cfg_taken),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("som_winner_and_weight_update_top verification failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(som_pkg::som_in_t it);
    int gap, n0;
    gap = $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    start <= 1'b1;
    n0 = items_taken;
    do @(negedge clk); while (items_taken == n0);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    int n0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    n0 = cfg_taken;
    do @(negedge clk); while (cfg_taken == n0);
    cfg_valid <= 1'b0;
    repeat ($urandom_range(0, 17)) @(negedge clk);
  endtask

  function automatic som_pkg::som_in_t mk(logic [1:0] f, int r, int c, int e, logic [31:0] w,
                                          logic [15:0] s, logic l);
    som_pkg::som_in_t it;
    it.func = f;
    it.neuron_row = 3'(r);
    it.neuron_col = 3'(c);
    it.element_index = 10'(e);
    it.weight_in = w;
    it.sample_value = s;
    it.last_element = l;
    return it;
  endfunction

  // mostly in-grid addresses, some past the grid; in-grid reads stay on preloaded elements
  function automatic som_pkg::som_in_t rand_access(logic [1:0] f);
    int r, c, e;
    r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 4);
    c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 4);
    e = $urandom_range(0, PreloadLen - 1);
    if (r > 4 || c > 4 || (f == som_pkg::FuncWrite && $urandom_range(0, 3) == 0))
      e = $urandom_range(0, 1023);
    return mk(f, r, c, e, $urandom, $urandom, $urandom_range(0, 1));
  endfunction

  task automatic short_vector(int len);
    for (int i = 0; i < len; i++)
      send(mk(som_pkg::FuncSample, $urandom_range(0, 7), $urandom_range(0, 7),
              $urandom_range(0, 1023), $urandom, $urandom, i == len - 1));
    open_elems = 0;
  endtask

  task automatic random_phase(int count);
    int done, pick, len;
    logic mark;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = $urandom_range(1, 12);
        short_vector(len);
        done += len;
      end else if (pick < 82) begin
        send(rand_access(som_pkg::FuncRead));
        done++;
      end else if (pick < 92) begin
        send(rand_access(som_pkg::FuncWrite));
        done++;
      end else if (pick < 96) begin
        send(rand_access(FuncUnused));
        done++;
      end else begin
        // loose element with a random mark, kept within the preloaded elements
        mark = (open_elems >= MaxLooseOpen) ? 1'b1 : 1'($urandom_range(0, 1));
        send(mk(som_pkg::FuncSample, 0, 0, 0, $urandom, $urandom, mark));
        open_elems = mark ? 0 : open_elems + 1;
        done++;
      end
    end
  endtask

  initial begin
    logic [15:0] rates [6];
    logic [15:0] radii [6];
    rst_n = 1'b0;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    open_elems = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // preload the leading elements of every neuron so no sample or read
    // touches an unwritten weight
    for (int k = 0; k < 25; k++)
      for (int e = 0; e < PreloadLen; e++)
        send(mk(som_pkg::FuncWrite, k / 5, k % 5, e, $urandom, '0, 1'b0));

    // directed
    send(mk(som_pkg::FuncWrite, 0, 0, 0, 32'hFFFF_FFFF, '0, 1'b0));
    send(mk(som_pkg::FuncWrite, 4, 4, 1023, 32'h0, '0, 1'b0));
    send(mk(som_pkg::FuncRead, 0, 0, 0, '0, '0, 1'b0));
    send(mk(som_pkg::FuncRead, 4, 4, 1023, '0, '0, 1'b0));
    send(mk(som_pkg::FuncWrite, 5, 0, 3, 32'h1234_5678, '0, 1'b0));
    send(mk(som_pkg::FuncWrite, 0, 7, 3, 32'h1234_5678, '0, 1'b0));
    send(mk(som_pkg::FuncRead, 7, 7, 1023, '0, '0, 1'b0));
    send(mk(som_pkg::FuncRead, 2, 5, 0, '0, '0, 1'b0));
    send(mk(FuncUnused, 7, 7, 1023, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    send(mk(som_pkg::FuncSample, 0, 0, 0, '0, 16'hFFFF, 1'b1));
    send(mk(som_pkg::FuncSample, 0, 0, 0, '0, 16'h0000, 1'b0));
    send(mk(som_pkg::FuncWrite, 3, 2, 1, 32'h8000_0000, '0, 1'b0));
    send(mk(som_pkg::FuncSample, 0, 0, 0, '0, 16'h8000, 1'b1));
    // equal weights everywhere: tie goes to the first neuron
    for (int k = 0; k < 25; k++)
      send(mk(som_pkg::FuncWrite, k / 5, k % 5, 0, 32'h0042_0000, '0, 1'b0));
    send(mk(som_pkg::FuncSample, 0, 0, 0, '0, 16'h0010, 1'b1));
    send(mk(som_pkg::FuncRead, 0, 0, 0, '0, '0, 1'b0));
    send(mk(som_pkg::FuncRead, 4, 4, 0, '0, '0, 1'b0));
    settle();

    rates = '{16'd0, 16'd65535, 16'd65535, 16'd1311, 16'd40000, 16'd0};
    radii = '{16'd1, 16'd65535, 16'd1, 16'd0, 16'd341, 16'd0};
    rates[4] = $urandom;
    radii[4] = $urandom_range(1, 65535);
    for (int p = 0; p < 6; p++) begin
      write_reg(som_pkg::RegLearningRate, rates[p]);
      write_reg(som_pkg::RegInvRadius, radii[p]);
      random_phase(185);
      settle();
    end

    if (fail_count == 0) begin
      $display("som_winner_and_weight_update_top verification clean");
    end else begin
      $display("som_winner_and_weight_update_top verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/som_pkg.sv
rtl/core/som_ram.sv
rtl/core/som_mul.sv
rtl/core/som_winner_and_weight_update_top.sv
bench/som_training_checker.sv
bench/tb_som_winner_and_weight_update_top.sv
